// ===== src/ssp_pkg.sv =====
package ssp_pkg;

    localparam int PAGE_SPACE  = 4096;
    localparam int ALIGN_BYTES = 1;
    localparam int MAX_SLOTS   = 1024;
    localparam int SLOT_WORD   = 4;

    localparam int AW = $clog2(PAGE_SPACE);   // byte address width
    localparam int CW = AW + 1;               // byte count width
    localparam int SW = $clog2(MAX_SLOTS);    // slot index width
    localparam int FW = SW + 1;               // slot count width
    localparam int NW = ((CW > FW + 3) ? CW : FW + 3) + 1;

    localparam logic [CW-1:0] TOP_OFFSET =
        CW'(PAGE_SPACE - (PAGE_SPACE % ALIGN_BYTES) - SLOT_WORD);

    typedef enum logic [1:0] {
        OP_BYTE   = 2'd0,
        OP_REMOVE = 2'd1,
        OP_CLEAR  = 2'd2
    } t_op;

    typedef enum logic [1:0] {
        ST_DONE   = 2'd0,
        ST_REJECT = 2'd1,
        ST_BADNUM = 2'd2
    } t_status;

    function automatic logic [CW-1:0] round_up(input logic [CW-1:0] n);
        logic [CW:0] t;
        t = {1'b0, n} + (CW+1)'(ALIGN_BYTES - 1);
        return CW'(t - (t % ALIGN_BYTES));
    endfunction

    function automatic logic [NW-1:0] round_down(input logic [NW-1:0] n);
        return NW'(n - (n % ALIGN_BYTES));
    endfunction

endpackage

// ===== src/ssp_ram.sv =====
module ssp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

// ===== src/sorted_slotted_page.sv =====
// Channel   Direction  Handshake            Payload
// input     in         i_valid / o_stall    i_operation, i_entry_byte, i_entry_last,
//                                           i_entry_number
// result    out        o_valid / i_stall    o_status, o_position, o_slot_count,
//                                           o_free_space
//
// A non-final entry byte is only staged. A final byte is checked against the free
// space, copied into the page and compared with the stored entries from the last slot
// downwards until its place is found; a rejected insert goes straight to its result.
// A remove closes the slot gap, moves the data below the hole up and fixes offsets.
// Reset is synchronous and active low; no memory is cleared after reset.
// The block stalls its input while it works and until a result has been
// moved into the output register, which holds while the result is stalled.
module sorted_slotted_page (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [1:0]  i_operation,
    input  logic [7:0]  i_entry_byte,
    input  logic        i_entry_last,
    input  logic [9:0]  i_entry_number,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [1:0]  o_status,
    output logic [9:0]  o_position,
    output logic [9:0]  o_slot_count,
    output logic [11:0] o_free_space
);

    localparam int AW = ssp_pkg::AW;
    localparam int CW = ssp_pkg::CW;
    localparam int SW = ssp_pkg::SW;
    localparam int FW = ssp_pkg::FW;
    localparam int NW = ssp_pkg::NW;

    typedef enum logic [3:0] {
        S_IDLE, S_INS_CHK, S_CPY, S_WALK, S_WALK_W, S_CMP, S_DECIDE, S_PLACE,
        S_RM_RD, S_RM_SH, S_MV, S_FIX, S_EMIT
    } t_state;

    t_state           r_state;
    logic [CW-1:0]    r_db;
    logic [FW-1:0]    r_filled;
    logic [CW-1:0]    r_scnt;
    logic [CW-1:0]    r_len;
    logic [CW-1:0]    r_cmplen;
    logic [CW-1:0]    r_bj;
    logic [AW-1:0]    r_bwa;
    logic [FW-1:0]    r_si;
    logic [FW-1:0]    r_sj;
    logic [SW-1:0]    r_swa;
    logic [AW-1:0]    r_off;
    logic [AW-1:0]    r_dlen;
    logic             r_rdv;
    logic             r_cgt;
    logic             r_ceq;
    logic [FW-1:0]    r_pos;
    ssp_pkg::t_status r_st;

    // Memory ports.
    logic          stg_we, pg_we, doff_we, dlen_we;
    logic [AW-1:0] stg_wa, stg_ra, pg_wa, pg_ra;
    logic [7:0]    stg_wd, stg_rd, pg_wd, pg_rd;
    logic [SW-1:0] dir_wa, dir_ra;
    logic [AW-1:0] doff_wd, dlen_wd, doff_rd, dlen_rd;

    logic          w_acc;
    logic          w_room;
    logic [CW-1:0] w_cnt_next;
    logic [FW-1:0] w_num;
    logic [FW-1:0] w_num_m1;
    logic [NW-1:0] w_need;
    logic [NW-1:0] w_free;
    logic          w_brk;
    logic [31:0]   w_free32;
    logic [31:0]   w_pos32;
    logic [31:0]   w_cnt32;

    assign o_stall    = (r_state != S_IDLE);
    assign w_acc      = i_valid && (r_state == S_IDLE);
    assign w_room     = (r_scnt < CW'(ssp_pkg::PAGE_SPACE));
    assign w_cnt_next = r_scnt + CW'(w_room);
    assign w_num      = FW'(i_entry_number);
    assign w_num_m1   = w_num - FW'(1);

    // Free space is the gap between directory (plus one slot) and data.
    always_comb begin
        w_need = (NW'(r_filled) + NW'(1)) * NW'(ssp_pkg::SLOT_WORD);
        if (NW'(r_db) < w_need) begin
            w_free = '0;
        end else begin
            w_free = ssp_pkg::round_down(NW'(r_db) - w_need);
        end
    end

    // The new entry goes after a slot that compares lower, or that is an
    // equal prefix no longer than the new entry.
    assign w_brk = r_cgt || (r_ceq && (r_len >= CW'(r_dlen)));

    assign w_free32 = 32'(w_free);
    assign w_pos32  = 32'(r_pos);
    assign w_cnt32  = 32'(r_filled);

    always_comb begin
        stg_we  = 1'b0;
        stg_wa  = r_scnt[AW-1:0];
        stg_wd  = i_entry_byte;
        stg_ra  = r_bj[AW-1:0];
        pg_we   = 1'b0;
        pg_wa   = r_bwa;
        pg_wd   = stg_rd;
        pg_ra   = AW'(CW'(r_off) + r_bj);
        doff_we = 1'b0;
        dlen_we = 1'b0;
        dir_wa  = r_swa;
        doff_wd = doff_rd;
        dlen_wd = dlen_rd;
        dir_ra  = r_sj[SW-1:0];
        case (r_state)
            S_IDLE: begin
                if (w_acc && (i_operation == ssp_pkg::OP_BYTE) && w_room) begin
                    stg_we = 1'b1;
                end
                dir_ra = w_num_m1[SW-1:0];
            end
            S_CPY: begin
                pg_we = r_rdv;
            end
            S_WALK: begin
                dir_ra = SW'(r_si - FW'(1));
            end
            S_DECIDE: begin
                doff_we = !w_brk;
                dlen_we = !w_brk;
                dir_wa  = r_si[SW-1:0];
                doff_wd = r_off;
                dlen_wd = r_dlen;
            end
            S_PLACE: begin
                doff_we = 1'b1;
                dlen_we = 1'b1;
                dir_wa  = r_si[SW-1:0];
                doff_wd = r_db[AW-1:0];
                dlen_wd = r_len[AW-1:0];
            end
            S_RM_SH: begin
                dir_ra  = SW'(r_sj + FW'(1));
                doff_we = r_rdv;
                dlen_we = r_rdv;
            end
            S_MV: begin
                pg_ra = AW'(r_bj - CW'(1));
                pg_we = r_rdv;
                pg_wd = pg_rd;
            end
            S_FIX: begin
                doff_we = r_rdv && (doff_rd < r_off);
                doff_wd = AW'(CW'(doff_rd) + r_len);
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_db     <= ssp_pkg::TOP_OFFSET;
            r_filled <= '0;
            r_scnt   <= '0;
            r_rdv    <= 1'b0;
            o_valid  <= 1'b0;
        end else begin
            // A result taken by the consumer leaves the output register,
            // unless a new one is loaded in the same cycle.
            if (o_valid && !i_stall && (r_state != S_EMIT)) begin
                o_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_acc) begin
                        case (i_operation)
                            ssp_pkg::OP_BYTE: begin
                                if (i_entry_last) begin
                                    r_len   <= w_cnt_next;
                                    r_scnt  <= '0;
                                    r_state <= S_INS_CHK;
                                end else begin
                                    r_scnt  <= w_cnt_next;
                                end
                            end
                            ssp_pkg::OP_REMOVE: begin
                                if ((w_num == '0) || (w_num > r_filled)) begin
                                    r_st    <= ssp_pkg::ST_BADNUM;
                                    r_pos   <= '0;
                                    r_state <= S_EMIT;
                                end else begin
                                    r_st    <= ssp_pkg::ST_DONE;
                                    r_pos   <= w_num;
                                    r_sj    <= w_num_m1;
                                    r_state <= S_RM_RD;
                                end
                            end
                            ssp_pkg::OP_CLEAR: begin
                                r_filled <= '0;
                                r_db     <= ssp_pkg::TOP_OFFSET;
                                r_scnt   <= '0;
                                r_st     <= ssp_pkg::ST_DONE;
                                r_pos    <= '0;
                                r_state  <= S_EMIT;
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                S_INS_CHK: begin
                    if ((r_len == '0) || (NW'(r_len) > w_free) ||
                        (r_filled >= FW'(ssp_pkg::MAX_SLOTS))) begin
                        r_st    <= ssp_pkg::ST_REJECT;
                        r_pos   <= '0;
                        r_state <= S_EMIT;
                    end else begin
                        r_db    <= r_db - ssp_pkg::round_up(r_len);
                        r_bj    <= '0;
                        r_rdv   <= 1'b0;
                        r_state <= S_CPY;
                    end
                end
                S_CPY: begin
                    // Staged byte j is read, then written to page in the next cycle.
                    if (r_bj < r_len) begin
                        r_bwa <= AW'(r_db + r_bj);
                        r_bj  <= r_bj + CW'(1);
                        r_rdv <= 1'b1;
                    end else begin
                        r_rdv <= 1'b0;
                        if (!r_rdv) begin
                            r_si    <= r_filled;
                            r_state <= S_WALK;
                        end
                    end
                end
                S_WALK: begin
                    if (r_si == '0) begin
                        r_state <= S_PLACE;
                    end else begin
                        r_state <= S_WALK_W;
                    end
                end
                S_WALK_W: begin
                    r_off    <= doff_rd;
                    r_dlen   <= dlen_rd;
                    r_cmplen <= (CW'(dlen_rd) < r_len) ? CW'(dlen_rd) : r_len;
                    r_bj     <= '0;
                    r_rdv    <= 1'b0;
                    r_state  <= S_CMP;
                end
                S_CMP: begin
                    if (r_rdv && (stg_rd != pg_rd)) begin
                        r_cgt   <= (stg_rd > pg_rd);
                        r_ceq   <= 1'b0;
                        r_rdv   <= 1'b0;
                        r_state <= S_DECIDE;
                    end else if ((r_bj == r_cmplen) && !r_rdv) begin
                        r_cgt   <= 1'b0;
                        r_ceq   <= 1'b1;
                        r_state <= S_DECIDE;
                    end else begin
                        r_rdv <= (r_bj < r_cmplen);
                        if (r_bj < r_cmplen) begin
                            r_bj <= r_bj + CW'(1);
                        end
                    end
                end
                S_DECIDE: begin
                    if (w_brk) begin
                        r_state <= S_PLACE;
                    end else begin
                        r_si    <= r_si - FW'(1);
                        r_state <= S_WALK;
                    end
                end
                S_PLACE: begin
                    r_filled <= r_filled + FW'(1);
                    r_pos    <= r_si + FW'(1);
                    r_st     <= ssp_pkg::ST_DONE;
                    r_state  <= S_EMIT;
                end
                S_RM_RD: begin
                    r_off   <= doff_rd;
                    r_len   <= ssp_pkg::round_up(CW'(dlen_rd));
                    r_rdv   <= 1'b0;
                    r_state <= S_RM_SH;
                end
                S_RM_SH: begin
                    // Slot j+1 is read, then written to slot j.
                    if ((r_sj + FW'(1)) < r_filled) begin
                        r_swa <= r_sj[SW-1:0];
                        r_sj  <= r_sj + FW'(1);
                        r_rdv <= 1'b1;
                    end else begin
                        r_rdv <= 1'b0;
                        if (!r_rdv) begin
                            r_bj    <= CW'(r_off);
                            r_state <= S_MV;
                        end
                    end
                end
                S_MV: begin
                    // Data below the removed entry moves up, highest byte first.
                    if (r_bj > r_db) begin
                        r_bwa <= AW'(r_bj - CW'(1) + r_len);
                        r_bj  <= r_bj - CW'(1);
                        r_rdv <= 1'b1;
                    end else begin
                        r_rdv <= 1'b0;
                        if (!r_rdv) begin
                            r_db     <= r_db + r_len;
                            r_filled <= r_filled - FW'(1);
                            r_sj     <= '0;
                            r_state  <= S_FIX;
                        end
                    end
                end
                S_FIX: begin
                    if (r_sj < r_filled) begin
                        r_swa <= r_sj[SW-1:0];
                        r_sj  <= r_sj + FW'(1);
                        r_rdv <= 1'b1;
                    end else begin
                        r_rdv <= 1'b0;
                        if (!r_rdv) begin
                            r_state <= S_EMIT;
                        end
                    end
                end
                S_EMIT: begin
                    if (!o_valid || !i_stall) begin
                        o_valid      <= 1'b1;
                        o_status     <= r_st;
                        o_position   <= w_pos32[9:0];
                        o_slot_count <= w_cnt32[9:0];
                        o_free_space <= w_free32[11:0];
                        r_state      <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    ssp_ram #(.WIDTH(8), .DEPTH(ssp_pkg::PAGE_SPACE)) u_stg (
        .i_clk(i_clk), .i_we(stg_we), .i_waddr(stg_wa), .i_wdata(stg_wd),
        .i_raddr(stg_ra), .o_rdata(stg_rd)
    );

    ssp_ram #(.WIDTH(8), .DEPTH(ssp_pkg::PAGE_SPACE)) u_page (
        .i_clk(i_clk), .i_we(pg_we), .i_waddr(pg_wa), .i_wdata(pg_wd),
        .i_raddr(pg_ra), .o_rdata(pg_rd)
    );

    ssp_ram #(.WIDTH(AW), .DEPTH(ssp_pkg::MAX_SLOTS)) u_doff (
        .i_clk(i_clk), .i_we(doff_we), .i_waddr(dir_wa), .i_wdata(doff_wd),
        .i_raddr(dir_ra), .o_rdata(doff_rd)
    );

    ssp_ram #(.WIDTH(AW), .DEPTH(ssp_pkg::MAX_SLOTS)) u_dlen (
        .i_clk(i_clk), .i_we(dlen_we), .i_waddr(dir_wa), .i_wdata(dlen_wd),
        .i_raddr(dir_ra), .o_rdata(dlen_rd)
    );

endmodule

// ===== sim/tb_sorted_slotted_page.sv =====
`timescale 1ns / 100ps

// Testbench for the sorted slotted page. A short table of directed items comes
// first, then about two thousand random items. Every accepted item is also run
// through a local model of the page, and each result that the block hands out
// is compared with the oldest prediction.
module tb_sorted_slotted_page;

    localparam int PAGE_SPACE  = ssp_pkg::PAGE_SPACE;
    localparam int ALIGN_BYTES = ssp_pkg::ALIGN_BYTES;
    localparam int MAX_SLOTS   = ssp_pkg::MAX_SLOTS;
    localparam int SLOT_WORD   = ssp_pkg::SLOT_WORD;
    localparam int TOP_OFFSET  = int'(ssp_pkg::TOP_OFFSET);

    localparam ssp_pkg::t_op     OP_BYTE   = ssp_pkg::OP_BYTE;
    localparam ssp_pkg::t_op     OP_REMOVE = ssp_pkg::OP_REMOVE;
    localparam ssp_pkg::t_op     OP_CLEAR  = ssp_pkg::OP_CLEAR;
    localparam ssp_pkg::t_status ST_DONE   = ssp_pkg::ST_DONE;
    localparam ssp_pkg::t_status ST_REJECT = ssp_pkg::ST_REJECT;
    localparam ssp_pkg::t_status ST_BADNUM = ssp_pkg::ST_BADNUM;

    localparam int WATCHDOG_LIMIT = 200000;
    localparam int RANDOM_ITEMS   = 2000;
    localparam int FRESH_FREE     = TOP_OFFSET - SLOT_WORD;

    // One result of the block.
    typedef struct packed {
        logic [1:0]  status;
        logic [9:0]  position;
        logic [9:0]  slot_count;
        logic [11:0] free_space;
    } t_outcome;

    // One directed row: the item, and a typed-in outcome where one is given.
    typedef struct packed {
        logic [1:0] op;
        logic [7:0] data;
        logic       last;
        logic [9:0] number;
        logic       typed;
        t_outcome   outcome;
    } t_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_stall;
    logic [1:0]  i_operation;
    logic [7:0]  i_entry_byte;
    logic        i_entry_last;
    logic [9:0]  i_entry_number;
    logic        o_valid;
    logic        i_stall;
    logic [1:0]  o_status;
    logic [9:0]  o_position;
    logic [9:0]  o_slot_count;
    logic [11:0] o_free_space;

    sorted_slotted_page u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_operation    (i_operation),
        .i_entry_byte   (i_entry_byte),
        .i_entry_last   (i_entry_last),
        .i_entry_number (i_entry_number),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_status       (o_status),
        .o_position     (o_position),
        .o_slot_count   (o_slot_count),
        .o_free_space   (o_free_space)
    );

    // The clock runs with a 2 ns period.
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Shadow copy of the page that the predictions are made from.
    logic [7:0]  page_mem [PAGE_SPACE];
    logic [7:0]  entry_buf [PAGE_SPACE];
    int unsigned slot_off [MAX_SLOTS];
    int unsigned slot_len [MAX_SLOTS];
    int unsigned slots_used;
    int unsigned data_top;
    int unsigned entry_fill;

    t_outcome    pending_results [$];
    int unsigned mismatches   = 0;
    int unsigned results_seen = 0;
    int unsigned items_sent;
    int unsigned rejects_seen = 0;
    int unsigned badnum_seen  = 0;
    int unsigned idle_cycles  = 0;
    logic        steady_run;   // when set, neither side idles

    function automatic int unsigned align_up(int unsigned n);
        return ((n + ALIGN_BYTES - 1) / ALIGN_BYTES) * ALIGN_BYTES;
    endfunction

    function automatic int unsigned page_free();
        int unsigned need;
        need = (slots_used + 1) * SLOT_WORD;
        if (data_top < need) return 0;
        return ((data_top - need) / ALIGN_BYTES) * ALIGN_BYTES;
    endfunction

    function automatic t_outcome make_outcome(ssp_pkg::t_status st, int unsigned pos);
        t_outcome r;
        r.status     = st;
        r.position   = pos[9:0];
        r.slot_count = slots_used[9:0];
        r.free_space = 12'(page_free());
        return r;
    endfunction

    // Order of the staged entry against a stored one: -1, 0 or 1 over the
    // shorter length, compared as unsigned bytes.
    function automatic int order_vs_slot(int unsigned k, int unsigned n);
        int unsigned span;
        span = (slot_len[k] < n) ? slot_len[k] : n;
        for (int unsigned b = 0; b < span; b++) begin
            if (entry_buf[b] != page_mem[slot_off[k] + b])
                return (entry_buf[b] > page_mem[slot_off[k] + b]) ? 1 : -1;
        end
        return 0;
    endfunction

    // Apply one accepted item to the shadow page. Returns 1 when the item
    // produces a result, which is then written to res.
    function automatic bit page_step(input t_row it, output t_outcome res);
        int unsigned n, k, width, gap, j;
        int          c;
        res = '0;
        case (ssp_pkg::t_op'(it.op))
            OP_BYTE: begin
                if (entry_fill < PAGE_SPACE) begin
                    entry_buf[entry_fill] = it.data;
                    entry_fill++;
                end
                if (!it.last) return 0;
                n = entry_fill;
                entry_fill = 0;
                if (n < 1 || n > page_free() || slots_used >= MAX_SLOTS) begin
                    res = make_outcome(ST_REJECT, 0);
                    return 1;
                end
                data_top -= align_up(n);
                for (int unsigned b = 0; b < n; b++) page_mem[data_top + b] = entry_buf[b];
                // Walk down from the end and shift every slot that sorts higher.
                k = slots_used;
                while (k > 0) begin
                    c = order_vs_slot(k - 1, n);
                    if (c > 0 || (c == 0 && n >= slot_len[k - 1])) break;
                    slot_off[k] = slot_off[k - 1];
                    slot_len[k] = slot_len[k - 1];
                    k--;
                end
                slot_off[k] = data_top;
                slot_len[k] = n;
                slots_used++;
                res = make_outcome(ST_DONE, k + 1);
                return 1;
            end
            OP_REMOVE: begin
                n = it.number;
                if (n < 1 || n > slots_used) begin
                    res = make_outcome(ST_BADNUM, 0);
                    return 1;
                end
                k = n - 1;
                width = align_up(slot_len[k]);
                gap = slot_off[k];
                for (j = k; j + 1 < slots_used; j++) begin
                    slot_off[j] = slot_off[j + 1];
                    slot_len[j] = slot_len[j + 1];
                end
                // Slide the data below the hole up by the removed width.
                if (gap > data_top) begin
                    for (int b = int'(gap) - 1; b >= int'(data_top); b--)
                        page_mem[b + width] = page_mem[b];
                end
                data_top += width;
                slots_used--;
                for (j = 0; j < slots_used; j++)
                    if (slot_off[j] < gap) slot_off[j] += width;
                res = make_outcome(ST_DONE, n);
                return 1;
            end
            OP_CLEAR: begin
                slots_used = 0;
                data_top = TOP_OFFSET;
                entry_fill = 0;
                res = make_outcome(ST_DONE, 0);
                return 1;
            end
            default: return 0;
        endcase
    endfunction

    // Present one item, hold it until accepted, then record its prediction.
    // A typed-in outcome, where given, replaces the predicted one.
    task automatic send_item(input t_row it);
        t_outcome predicted;
        bit       produces;
        while (!steady_run && $urandom_range(0, 99) < 29) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid        <= 1'b1;
        i_operation    <= it.op;
        i_entry_byte   <= it.data;
        i_entry_last   <= it.last;
        i_entry_number <= it.number;
        do @(posedge i_clk); while (o_stall);
        items_sent++;
        produces = page_step(it, predicted);
        if (produces) pending_results.push_back(it.typed ? it.outcome : predicted);
    endtask

    function automatic t_row make_item(ssp_pkg::t_op op, logic [7:0] data, logic last,
                                       logic [9:0] number);
        t_row r;
        r = '0;
        r.op = op;
        r.data = data;
        r.last = last;
        r.number = number;
        return r;
    endfunction

    // Entry bytes come mostly from a small alphabet so that equal prefixes
    // and exact duplicates show up often in the sort.
    function automatic logic [7:0] pick_byte();
        case ($urandom_range(0, 4))
            0: return 8'h00;
            1: return 8'h01;
            2: return 8'hFF;
            3: return 8'($urandom_range(0, 3));
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic send_entry(input int unsigned n);
        for (int unsigned b = 0; b < n; b++)
            send_item(make_item(OP_BYTE, pick_byte(), (b == n - 1) ? 1'b1 : 1'b0,
                                10'($urandom_range(0, 1023))));
    endtask

    // Result side: random stalls, and the check against the oldest prediction.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            if (o_valid && !i_stall) begin
                t_outcome got;
                got = {o_status, o_position, o_slot_count, o_free_space};
                results_seen++;
                if (pending_results.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result: status %0d pos %0d count %0d free %0d",
                                 o_status, o_position, o_slot_count, o_free_space);
                end else begin
                    t_outcome want;
                    want = pending_results.pop_front();
                    if (want.status == ST_REJECT) rejects_seen++;
                    if (want.status == ST_BADNUM) badnum_seen++;
                    if (got != want) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display({"result %0d: expected status %0d pos %0d count %0d",
                                      " free %0d, got status %0d pos %0d count %0d free %0d"},
                                     results_seen, want.status, want.position,
                                     want.slot_count, want.free_space, o_status,
                                     o_position, o_slot_count, o_free_space);
                    end
                end
            end
            i_stall <= !steady_run && ($urandom_range(0, 99) < 29);
        end
    end

    // The watchdog counts cycles in which neither channel moves an item.
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog expired with %0d results outstanding",
                     pending_results.size());
            $display("sorted_slotted_page verification failed");
            $finish;
        end
    end

    // Directed items. Typed-in outcomes cover the empty page, the extremes of
    // the entry number, bad numbers and a few inserts whose slot is obvious.
    localparam int ROWS = 19;
    t_row directed [ROWS];

    initial begin
        directed = '{
            '{OP_CLEAR,  8'h00, 1'b0, 10'd0,    1'b1, '{ST_DONE,   10'd0, 10'd0, 12'(FRESH_FREE)}},
            '{OP_REMOVE, 8'h00, 1'b0, 10'd0,    1'b1, '{ST_BADNUM, 10'd0, 10'd0, 12'(FRESH_FREE)}},
            '{OP_REMOVE, 8'hFF, 1'b1, 10'd1023, 1'b1, '{ST_BADNUM, 10'd0, 10'd0, 12'(FRESH_FREE)}},
            '{OP_BYTE,   8'hFF, 1'b1, 10'd1023, 1'b1, '{ST_DONE, 10'd1, 10'd1, 12'(FRESH_FREE - 5)}},
            '{OP_BYTE,   8'h00, 1'b1, 10'd0,    1'b1, '{ST_DONE, 10'd1, 10'd2, 12'(FRESH_FREE - 10)}},
            // An entry with an equal prefix and more bytes sorts after the shorter one.
            '{OP_BYTE,   8'h00, 1'b0, 10'd0,    1'b0, '0},
            '{OP_BYTE,   8'h00, 1'b1, 10'd0,    1'b1, '{ST_DONE, 10'd2, 10'd3, 12'(FRESH_FREE - 16)}},
            // A remove in the middle of an insert keeps the bytes staged so far.
            '{OP_BYTE,   8'h80, 1'b0, 10'd0,    1'b0, '0},
            '{OP_REMOVE, 8'h00, 1'b0, 10'd1,    1'b1, '{ST_DONE, 10'd1, 10'd2, 12'(FRESH_FREE - 11)}},
            '{OP_BYTE,   8'h55, 1'b1, 10'd0,    1'b0, '0},
            // A clear in the middle of an insert drops the staged bytes.
            '{OP_BYTE,   8'hAA, 1'b0, 10'd0,    1'b0, '0},
            '{OP_CLEAR,  8'h00, 1'b1, 10'd1023, 1'b1, '{ST_DONE,   10'd0, 10'd0, 12'(FRESH_FREE)}},
            '{OP_BYTE,   8'h01, 1'b1, 10'd0,    1'b1, '{ST_DONE, 10'd1, 10'd1, 12'(FRESH_FREE - 5)}},
            '{OP_REMOVE, 8'h00, 1'b0, 10'd2,    1'b1, '{ST_BADNUM, 10'd0, 10'd1, 12'(FRESH_FREE - 5)}},
            '{OP_REMOVE, 8'h00, 1'b0, 10'd1,    1'b1, '{ST_DONE,   10'd1, 10'd0, 12'(FRESH_FREE)}},
            // Exact duplicates land after the copies already present.
            '{OP_BYTE,   8'h07, 1'b1, 10'd0,    1'b1, '{ST_DONE, 10'd1, 10'd1, 12'(FRESH_FREE - 5)}},
            '{OP_BYTE,   8'h07, 1'b1, 10'd0,    1'b1, '{ST_DONE, 10'd2, 10'd2, 12'(FRESH_FREE - 10)}},
            '{OP_BYTE,   8'h06, 1'b1, 10'd0,    1'b0, '0},
            '{OP_REMOVE, 8'h00, 1'b0, 10'd2,    1'b0, '0}
        };
    end

    initial begin
        int unsigned roll;
        int unsigned drain;
        i_rst_n        = 1'b0;
        i_valid        = 1'b0;
        i_operation    = OP_CLEAR;
        i_entry_byte   = 8'h00;
        i_entry_last   = 1'b0;
        i_entry_number = 10'd0;
        steady_run     = 1'b0;
        items_sent     = 0;
        slots_used     = 0;
        data_top       = TOP_OFFSET;
        entry_fill     = 0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int r = 0; r < ROWS; r++) send_item(directed[r]);

        // An entry longer than the page saturates the staging count and is
        // always rejected.
        send_entry(PAGE_SPACE + 4);

        // Random part: mostly short inserts, with long ones to fill the page
        // and drive inserts into rejection, removes, and the odd clear.
        while (items_sent < RANDOM_ITEMS + PAGE_SPACE + ROWS) begin
            steady_run = (items_sent > 800 + PAGE_SPACE && items_sent < 1300 + PAGE_SPACE);
            roll = $urandom_range(0, 99);
            if (roll < 2) begin
                send_item(make_item(OP_CLEAR, 8'($urandom_range(0, 255)),
                                    1'($urandom_range(0, 1)), 10'($urandom_range(0, 1023))));
            end else if (roll < 28) begin
                send_item(make_item(OP_REMOVE, 8'($urandom_range(0, 255)),
                                    1'($urandom_range(0, 1)),
                                    ($urandom_range(0, 9) == 0 || slots_used == 0)
                                        ? 10'($urandom_range(0, 1023))
                                        : 10'($urandom_range(1, slots_used))));
            end else if (roll < 34) begin
                send_entry($urandom_range(100, 900));
            end else begin
                send_entry($urandom_range(1, 6));
            end
        end
        steady_run = 1'b0;
        i_valid <= 1'b0;

        // Wait for the last results, then give the block time to show any extra.
        while (pending_results.size() != 0) @(posedge i_clk);
        drain = 0;
        while (drain < 200) begin
            @(posedge i_clk);
            drain++;
        end

        $display("%0d items sent, %0d results checked (%0d rejected inserts, %0d bad numbers)",
                 items_sent, results_seen, rejects_seen, badnum_seen);
        $display("%0d mismatches", mismatches);
        if (mismatches == 0 && pending_results.size() == 0) begin
            $display("sorted_slotted_page verification clean");
        end else begin
            $display("sorted_slotted_page verification failed");
        end
        $finish;
    end

endmodule
